// File: rtl/core/qed_pkg.sv
// shared types, constants and helper functions for the quaternion to euler block
// no dependencies
`default_nettype none
package qed_pkg;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int ATAN_LEN = 24;
   localparam int CORDIC_STEPS = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
   localparam int STEP_W = 5;

   localparam int QW = 16;
   localparam int AW = 33;
   localparam int CW = 40;
   localparam int ZW = 34;
   localparam int TW = 30;
   localparam int SQW = 58;
   localparam int ROOT_STEPS = 29;

   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [CW-1:0] ONE_Q28 = 40'sd268435456;
   localparam logic signed [TW-1:0] ONE_T = 30'sd268435456;
   localparam logic signed [15:0] ROLL_YAW_MAX = 16'sd25736;
   localparam logic signed [15:0] PITCH_MAX = 16'sd12868;

   typedef struct packed {
      logic signed [CW-1:0] roll_num;
      logic signed [CW-1:0] roll_den;
      logic signed [CW-1:0] yaw_num;
      logic signed [CW-1:0] yaw_den;
      logic signed [TW-1:0] pitch_arg;
   } qed_entry_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0: v = 34'sd843314857;
         5'd1: v = 34'sd497837829;
         5'd2: v = 34'sd263043837;
         5'd3: v = 34'sd133525159;
         5'd4: v = 34'sd67021687;
         5'd5: v = 34'sd33543516;
         5'd6: v = 34'sd16775851;
         5'd7: v = 34'sd8388437;
         5'd8: v = 34'sd4194283;
         5'd9: v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                 input logic signed [15:0] limit);
      logic signed [ZW:0] s;
      logic signed [ZW:0] r;
      logic signed [ZW:0] lim;
      s = {z[ZW-1], z} + 35'sd65536;
      r = s >>> 17;
      lim = {{(ZW+1-16){limit[15]}}, limit};
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r[15:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/qed_if.sv
// request and response channel interfaces, valid/ready handshake
// depends on nothing
`default_nettype none
interface qed_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qed_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] roll_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic signed [16:0] roll_change;
   logic signed [15:0] pitch_change;
   logic signed [16:0] yaw_change;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, roll_change,
                   pitch_change, yaw_change, input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_angle, roll_change,
                 pitch_change, yaw_change, output ready);
endinterface
`default_nettype wire

// File: rtl/core/quaternion_to_euler_delta_top.sv
// from request to response: 9 front multiply steps, push,
// pop, square, 29 square-root steps, pitch cordic start, 16 cordic steps, output
// request rate is set by the back end square root and pitch cordic; the front
// takes the next request while the back works
// reset: synchronous, clears handshake state, queue and the stored angles to zero
// top level: qed_front, qed_fifo, qed_back
`default_nettype none
module quaternion_to_euler_delta_top (
   input  wire logic clock,
   input  wire logic reset,
   qed_req_if.sink   req_chan,
   qed_rsp_if.source rsp_chan
);
   import qed_pkg::*;

   qed_entry_type push_entry, pop_entry;
   logic push, pop, full, empty;

   qed_front u_front (
      .clock(clock), .reset(reset), .req(req_chan),
      .entry(push_entry), .push(push), .full(full)
   );

   qed_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .wr_data(push_entry),
      .pop(pop), .rd_data(pop_entry), .full(full), .empty(empty)
   );

   qed_back u_back (
      .clock(clock), .reset(reset), .entry(pop_entry), .empty(empty),
      .pop(pop), .rsp(rsp_chan)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue pop while empty");
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("front took a request while busy");
`endif
endmodule
`default_nettype wire

// File: rtl/core/qed_front.sv
// front end: accepts a quaternion and forms the atan2 and asin arguments
// one shared 16x16 multiplier over nine multiply steps; uses qed_pkg and qed_req_if
`default_nettype none
module qed_front (
   input  wire logic           clock,
   input  wire logic           reset,
   qed_req_if.sink             req,
   output qed_pkg::qed_entry_type entry,
   output logic                push,
   input  wire logic           full
);
   import qed_pkg::*;

   localparam logic [3:0] LAST_STEP = 4'd9;
   localparam logic signed [ZW-1:0] ONE_Z = ZW'(ONE_T);

   logic busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic signed [QW-1:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [AW-1:0] acc_r_ff, acc_rd_ff, acc_y_ff, acc_yd_ff, acc_t_ff;
   logic signed [QW-1:0] op_a, op_b;
   logic signed [2*QW-1:0] prod;
   logic signed [AW-1:0] prod_ext;
   logic signed [ZW-1:0] t2;
   logic signed [TW-1:0] t_clamped;
   logic accept;

   assign req.ready = !busy_ff;
   assign accept = req.valid && !busy_ff;

   always_comb begin
      case (step_ff)
         4'd0: begin op_a = w_ff; op_b = x_ff; end
         4'd1: begin op_a = y_ff; op_b = z_ff; end
         4'd2: begin op_a = x_ff; op_b = x_ff; end
         4'd3: begin op_a = y_ff; op_b = y_ff; end
         4'd4: begin op_a = z_ff; op_b = z_ff; end
         4'd5: begin op_a = w_ff; op_b = z_ff; end
         4'd6: begin op_a = x_ff; op_b = y_ff; end
         4'd7: begin op_a = w_ff; op_b = y_ff; end
         default: begin op_a = z_ff; op_b = x_ff; end
      endcase
      prod = op_a * op_b;
      prod_ext = {prod[2*QW-1], prod};
   end

   always_comb begin
      entry.roll_num = {{(CW-AW){acc_r_ff[AW-1]}}, acc_r_ff} <<< 1;
      entry.roll_den = ONE_Q28 - ({{(CW-AW){acc_rd_ff[AW-1]}}, acc_rd_ff} <<< 1);
      entry.yaw_num = {{(CW-AW){acc_y_ff[AW-1]}}, acc_y_ff} <<< 1;
      entry.yaw_den = ONE_Q28 - ({{(CW-AW){acc_yd_ff[AW-1]}}, acc_yd_ff} <<< 1);
      t2 = {acc_t_ff[AW-1], acc_t_ff} <<< 1;
      if (t2 > ONE_Z) begin
         t_clamped = ONE_T;
      end else if (t2 < -ONE_Z) begin
         t_clamped = -ONE_T;
      end else begin
         t_clamped = t2[TW-1:0];
      end
      entry.pitch_arg = t_clamped;
   end

   assign push = busy_ff && (step_ff == LAST_STEP) && !full;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff && step_ff != LAST_STEP) begin
         step_in = step_ff + 4'd1;
      end else if (push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff <= req.quat_w;
         x_ff <= req.quat_x;
         y_ff <= req.quat_y;
         z_ff <= req.quat_z;
         acc_r_ff <= '0;
         acc_rd_ff <= '0;
         acc_y_ff <= '0;
         acc_yd_ff <= '0;
         acc_t_ff <= '0;
      end else if (busy_ff) begin
         case (step_ff)
            4'd0, 4'd1: acc_r_ff <= acc_r_ff + prod_ext;
            4'd2: acc_rd_ff <= acc_rd_ff + prod_ext;
            4'd3: begin
               acc_rd_ff <= acc_rd_ff + prod_ext;
               acc_yd_ff <= acc_yd_ff + prod_ext;
            end
            4'd4: acc_yd_ff <= acc_yd_ff + prod_ext;
            4'd5, 4'd6: acc_y_ff <= acc_y_ff + prod_ext;
            4'd7: acc_t_ff <= acc_t_ff + prod_ext;
            4'd8: acc_t_ff <= acc_t_ff - prod_ext;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/qed_fifo.sv
// two-entry queue between front and back
// uses qed_pkg
`default_nettype none
module qed_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  qed_pkg::qed_entry_type wr_data,
   input  wire logic              pop,
   output qed_pkg::qed_entry_type rd_data,
   output logic                   full,
   output logic                   empty
);
   import qed_pkg::*;

   qed_entry_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = count_ff[1];
   assign empty = (count_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/qed_cordic.sv
// iterative cordic vectoring unit giving atan2 in q.30 radians
// uses qed_pkg
`default_nettype none
module qed_cordic (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [qed_pkg::CW-1:0] y_in,
   input  wire logic signed [qed_pkg::CW-1:0] x_in,
   output logic                              done,
   output logic signed [qed_pkg::ZW-1:0]     angle
);
   import qed_pkg::*;

   logic run_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic zero_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic signed [CW-1:0] dx, dy;

   assign done = !run_ff;
   assign angle = zero_ff ? '0 : z_ff;
   assign dx = x_ff >>> cnt_ff;
   assign dy = y_ff >>> cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= (y_in < 0) ? -PI_Q30 : PI_Q30;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= '0;
         end
      end else if (run_ff) begin
         if (y_ff < 0) begin
            x_ff <= x_ff - dy;
            y_ff <= y_ff + dx;
            z_ff <= z_ff - atan_entry(cnt_ff);
         end else begin
            x_ff <= x_ff + dy;
            y_ff <= y_ff - dx;
            z_ff <= z_ff + atan_entry(cnt_ff);
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/qed_back.sv
// back end: square root for the asin path, three cordic lanes, angle deltas
// uses qed_pkg, qed_rsp_if and qed_cordic
`default_nettype none
module qed_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  qed_pkg::qed_entry_type entry,
   input  wire logic              empty,
   output logic                   pop,
   qed_rsp_if.source              rsp
);
   import qed_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQUARE = 3'd1;
   localparam logic [2:0] S_ROOT = 3'd2;
   localparam logic [2:0] S_PITCH = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic signed [TW-1:0] t_ff;
   logic [SQW-1:0] rem_ff, res_ff, bit_ff;
   logic [SQW-1:0] trial;
   logic [TW-2:0] mag;
   logic [SQW-1:0] sq;
   logic pitch_start;
   logic roll_done, pitch_done, yaw_done;
   logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
   logic signed [15:0] roll_q, pitch_q, yaw_q;
   logic signed [15:0] last_roll_ff, last_yaw_ff;
   logic signed [14:0] last_pitch_ff;
   logic out_valid_ff;
   logic load_out;

   assign pop = (state_ff == S_IDLE) && !empty;
   assign mag = t_ff[TW-1] ? 29'(-t_ff) : t_ff[TW-2:0];
   assign sq = SQW'(mag) * SQW'(mag);
   assign trial = res_ff + bit_ff;
   assign pitch_start = (state_ff == S_ROOT) && (bit_ff == '0);
   assign load_out = (state_ff == S_DONE) && (!out_valid_ff || rsp.ready);

   qed_cordic u_roll (
      .clock(clock), .reset(reset), .start(pop),
      .y_in(entry.roll_num), .x_in(entry.roll_den),
      .done(roll_done), .angle(roll_z)
   );

   qed_cordic u_yaw (
      .clock(clock), .reset(reset), .start(pop),
      .y_in(entry.yaw_num), .x_in(entry.yaw_den),
      .done(yaw_done), .angle(yaw_z)
   );

   qed_cordic u_pitch (
      .clock(clock), .reset(reset), .start(pitch_start),
      .y_in({{(CW-TW){t_ff[TW-1]}}, t_ff}), .x_in(CW'(res_ff)),
      .done(pitch_done), .angle(pitch_z)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (pop) state_in = S_SQUARE;
         S_SQUARE: state_in = S_ROOT;
         S_ROOT: if (pitch_start) state_in = S_PITCH;
         S_PITCH: if (roll_done && yaw_done && pitch_done) state_in = S_DONE;
         S_DONE: if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // integer square root, two bits of radicand per cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         t_ff <= entry.pitch_arg;
      end
      if (state_ff == S_SQUARE) begin
         rem_ff <= (SQW'(1) << 56) - sq;
         res_ff <= '0;
         bit_ff <= SQW'(1) << 56;
      end else if (state_ff == S_ROOT && !pitch_start) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign roll_q = to_q13(roll_z, ROLL_YAW_MAX);
   assign pitch_q = to_q13(pitch_z, PITCH_MAX);
   assign yaw_q = to_q13(yaw_z, ROLL_YAW_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         last_roll_ff <= '0;
         last_pitch_ff <= '0;
         last_yaw_ff <= '0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
            last_roll_ff <= roll_q;
            last_pitch_ff <= pitch_q[14:0];
            last_yaw_ff <= yaw_q;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp.roll_angle <= roll_q;
         rsp.pitch_angle <= pitch_q[14:0];
         rsp.yaw_angle <= yaw_q;
         rsp.roll_change <= {roll_q[15], roll_q} - {last_roll_ff[15], last_roll_ff};
         rsp.pitch_change <= {pitch_q[14], pitch_q[14:0]}
                             - {last_pitch_ff[14], last_pitch_ff};
         rsp.yaw_change <= {yaw_q[15], yaw_q} - {last_yaw_ff[15], last_yaw_ff};
      end
   end

   assign rsp.valid = out_valid_ff;
endmodule
`default_nettype wire

// File: tb/qed_tb_checker.sv
// checker for the quaternion to euler block: predicts each response from the
// observed requests and compares it; depends on qed_pkg and qed_if
`default_nettype none
module qed_tb_checker (
   input wire logic clock,
   input wire logic reset,
   qed_req_if.sink  req_mon,
   qed_rsp_if.sink  rsp_mon,
   output int       fail_count,
   output int       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import qed_pkg::*;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic signed [16:0] roll_d;
      logic signed [15:0] pitch_d;
      logic signed [16:0] yaw_d;
   } euler_type;

   euler_type euler_q[$];
   longint prev_roll, prev_pitch, prev_yaw;
   int errors;

   localparam longint PI_L = 64'sd3373259426;
   localparam longint ONE_L = 64'sd268435456;
   localparam int N_ROT = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;

   function automatic longint atan_lut(int i);
      longint t [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
         33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
         131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
      return t[i];
   endfunction

   function automatic longint int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint yv, longint xv);
      longint zacc, dx, dy;
      zacc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         zacc = (yv < 0) ? -PI_L : PI_L;
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < N_ROT; i++) begin
         dx = xv >>> i;
         dy = yv >>> i;
         if (yv < 0) begin
            xv = xv - dy;
            yv = yv + dx;
            zacc = zacc - atan_lut(i);
         end else begin
            xv = xv + dy;
            yv = yv - dx;
            zacc = zacc + atan_lut(i);
         end
      end
      return zacc;
   endfunction

   function automatic longint rad_q13(longint zv, longint lim);
      longint r;
      r = (zv + 65536) >>> 17;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   always @(posedge clock) begin
      longint w, x, y, z, rn, rd, yn, yd, t, c, ro, pi, ya;
      euler_type e, got;
      if (reset) begin
         prev_roll = 0;
         prev_pitch = 0;
         prev_yaw = 0;
         euler_q.delete();
         errors = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            w = req_mon.quat_w;
            x = req_mon.quat_x;
            y = req_mon.quat_y;
            z = req_mon.quat_z;
            rn = 2 * (w * x + y * z);
            rd = ONE_L - 2 * (x * x + y * y);
            yn = 2 * (w * z + x * y);
            yd = ONE_L - 2 * (y * y + z * z);
            t = 2 * (w * y - z * x);
            if (t > ONE_L) t = ONE_L;
            if (t < -ONE_L) t = -ONE_L;
            c = int_root(longint'(ONE_L * ONE_L - t * t));
            ro = rad_q13(vector_angle(rn, rd), 25736);
            pi = rad_q13(vector_angle(t, c), 12868);
            ya = rad_q13(vector_angle(yn, yd), 25736);
            e.roll = ro[15:0];
            e.pitch = pi[14:0];
            e.yaw = ya[15:0];
            e.roll_d = 17'(ro - prev_roll);
            e.pitch_d = 16'(pi - prev_pitch);
            e.yaw_d = 17'(ya - prev_yaw);
            prev_roll = ro;
            prev_pitch = pi;
            prev_yaw = ya;
            euler_q.push_back(e);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (euler_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = euler_q.pop_front();
               got.roll = rsp_mon.roll_angle;
               got.pitch = rsp_mon.pitch_angle;
               got.yaw = rsp_mon.yaw_angle;
               got.roll_d = rsp_mon.roll_change;
               got.pitch_d = rsp_mon.pitch_change;
               got.yaw_d = rsp_mon.yaw_change;
               if (got.roll !== e.roll) begin
                  $error("roll_angle exp %0d got %0d", e.roll, got.roll); errors++;
               end
               if (got.pitch !== e.pitch) begin
                  $error("pitch_angle exp %0d got %0d", e.pitch, got.pitch); errors++;
               end
               if (got.yaw !== e.yaw) begin
                  $error("yaw_angle exp %0d got %0d", e.yaw, got.yaw); errors++;
               end
               if (got.roll_d !== e.roll_d) begin
                  $error("roll_change exp %0d got %0d", e.roll_d, got.roll_d); errors++;
               end
               if (got.pitch_d !== e.pitch_d) begin
                  $error("pitch_change exp %0d got %0d", e.pitch_d, got.pitch_d);
                  errors++;
               end
               if (got.yaw_d !== e.yaw_d) begin
                  $error("yaw_change exp %0d got %0d", e.yaw_d, got.yaw_d); errors++;
               end
            end
         end
      end
   end

   assign fail_count = errors;
   assign pending_count = euler_q.size();
endmodule
`default_nettype wire

// File: tb/quaternion_to_euler_delta_top_tb.sv
// testbench top: clock, reset, request stimulus and response back-pressure
// for quaternion_to_euler_delta_top; depends on qed_pkg, qed_if, qed_tb_checker
`default_nettype none
module quaternion_to_euler_delta_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1330;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count, pending_count;
   int send_idle_pct = 18;
   int recv_idle_pct = 86;
   bit hold_off = 1'b0;
   bit in_flood = 1'b0;
   int sent = 0;
   longint cycles = 0;

   qed_req_if req_chan ();
   qed_rsp_if rsp_chan ();

   quaternion_to_euler_delta_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   qed_tb_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #6 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.quat_w = '0;
      req_chan.quat_x = '0;
      req_chan.quat_y = '0;
      req_chan.quat_z = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("quaternion_to_euler_delta_top: mismatch");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(32768)) - 16384);
         default: return 16'(int'($urandom_range(8192)) - 4096);
      endcase
   endfunction

   task automatic send_quat(input logic [15:0] w, x, y, z, input bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.quat_w <= w;
      req_chan.quat_x <= x;
      req_chan.quat_y <= y;
      req_chan.quat_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_unit(input bit gaps);
      real a, b, c, d, n;
      a = $urandom_range(2000) - 1000.0;
      b = $urandom_range(2000) - 1000.0;
      c = $urandom_range(2000) - 1000.0;
      d = $urandom_range(2000) - 1000.0;
      if ($urandom_range(7) == 0) c = a + $urandom_range(4) - 2.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
         a = 1.0; n = 1.0;
      end
      send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)), gaps);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, axes, gimbal lock, extremes, zero, sign patterns
      send_quat(16'sd16384, 0, 0, 0, 1);
      send_quat(0, 0, 0, 0, 1);
      send_quat(16'sd11585, 16'sd11585, 0, 0, 1);
      send_quat(16'sd11585, 0, 16'sd11585, 0, 1);
      send_quat(16'sd11585, 0, 0, 16'sd11585, 1);
      send_quat(16'sd11585, 0, 16'sd11586, 0, 1);
      send_quat(16'sd11585, 0, -16'sd11586, 0, 1);
      send_quat(0, 16'sd16384, 0, 0, 1);
      send_quat(0, 0, 16'sd16384, 0, 1);
      send_quat(0, 0, 0, 16'sd16384, 1);
      send_quat(-16'sd16384, 0, 0, 0, 1);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1);
      send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1);
      send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1);
      send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1);
      send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1);
      send_quat(16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192, 1);
      send_quat(0, 16'sd11585, 0, -16'sd11585, 1);
      send_quat(16'sd1, 16'sd16383, 16'sd1, -16'sd1, 1);

      // random part, idle profile changes at each third
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 86;
            recv_idle_pct = 18;
         end
         if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i == 200) begin
            drain();
            repeat ($urandom_range(30)) @(posedge clock);
         end
         if (i == 900) begin
            hold_off = 1'b1;
            in_flood = 1'b1;
         end
         if ($urandom_range(9) < 8) send_unit(1);
         else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1);
      end
      drain();
      repeat (120) @(posedge clock);
      $display("sent %0d quaternions: unit, near gimbal lock, extreme and zero inputs",
               sent);
      $display("random sender/receiver stalls plus a long receiver hold-off");
      if (fail_count == 0) begin
         $display("quaternion_to_euler_delta_top: match");
      end else begin
         $display("quaternion_to_euler_delta_top: mismatch");
      end
      $finish;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (in_flood);
      repeat (600) @(posedge clock);
      hold_off = 1'b0;
   end
endmodule
`default_nettype wire
